@@ rtl/core/slat_pkg.sv @@
package slat_pkg;

    // default sizes of the tracker
    localparam int MAX_SET_INDEX_BITS_DEF = 10;
    localparam int MAX_WAYS_DEF           = 8;

    // fixed field widths
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 62;
    localparam int CNT_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int SIB_W      = 4;
    localparam int BOB_W      = 6;
    localparam int WIU_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int BOB_MAX    = 32;
    localparam int SHAMT_W    = 7;
    localparam int WAY_SEL_W  = 4;

    // access kinds
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;

    // result of one access
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_INDEX_BITS    = 2'd0,
        CFG_BLOCK_OFFSET_BITS = 2'd1,
        CFG_WAYS_IN_USE       = 2'd2
    } cfg_idx_t;

    // main sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // way scan verdict: what happened and which way it concerns
    typedef struct packed {
        outcome_t               kind;
        logic [WAY_SEL_W-1:0]   way;
    } scan_res_t;

    // bits needed to number n items, at least one
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

@@ rtl/core/slat_row_mem.sv @@
module slat_row_mem
    import slat_pkg::*;
#(
    parameter int SET_W = MAX_SET_INDEX_BITS_DEF,
    parameter int WAYS  = MAX_WAYS_DEF
)
(
    input  logic                                clk,
    input  logic                                meta_we,
    input  logic                                tag_we,
    input  logic [SET_W-1:0]                    wr_addr,
    input  logic [WAYS-1:0]                     wr_valid,
    input  logic [WAYS-1:0][idx_w(WAYS)-1:0]    wr_rank,
    input  logic [WAYS-1:0][TAG_W-1:0]          wr_tag,
    input  logic                                rd_en,
    input  logic [SET_W-1:0]                    rd_addr,
    output logic [WAYS-1:0]                     rd_valid,
    output logic [WAYS-1:0][idx_w(WAYS)-1:0]    rd_rank,
    output logic [WAYS-1:0][TAG_W-1:0]          rd_tag
);

    localparam int SETS   = 1 << SET_W;
    localparam int RANK_W = idx_w(WAYS);

    // one row per set: valid and rank bits, tags apart
    logic [WAYS-1:0][RANK_W:0]  meta_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0] tag_mem  [SETS];

    logic [WAYS-1:0][RANK_W:0]  wr_meta;
    logic [WAYS-1:0][RANK_W:0]  rd_meta_reg;
    logic [WAYS-1:0][TAG_W-1:0] rd_tag_reg;

    // pack and unpack valid with rank
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            wr_meta[w]  = {wr_valid[w], wr_rank[w]};
            rd_valid[w] = rd_meta_reg[w][RANK_W];
            rd_rank[w]  = rd_meta_reg[w][RANK_W-1:0];
        end
    end

    assign rd_tag = rd_tag_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[wr_addr] <= wr_meta;
        end
        if (tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_meta_reg <= meta_mem[rd_addr];
            rd_tag_reg  <= tag_mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/slat_way_scan.sv @@
module slat_way_scan
    import slat_pkg::*;
#(
    parameter int WAYS = MAX_WAYS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [idx_w(WAYS)-1:0]              last_way,
    input  logic [TAG_W-1:0]                    tag,
    input  logic [WAYS-1:0]                     row_valid,
    input  logic [WAYS-1:0][idx_w(WAYS)-1:0]    row_rank,
    input  logic [WAYS-1:0][TAG_W-1:0]          row_tag,
    output logic                                done,
    output scan_res_t                           res
);

    localparam int WAY_W  = idx_w(WAYS);
    localparam int RANK_W = idx_w(WAYS);

    logic              busy_reg;
    logic              done_reg;
    logic [WAY_W-1:0]  j_reg;
    logic              free_reg;
    logic              free_next;
    logic [WAY_W-1:0]  free_way_reg;
    logic [WAY_W-1:0]  free_way_next;
    logic [RANK_W-1:0] best_reg;
    logic [RANK_W-1:0] best_next;
    logic [WAY_W-1:0]  vic_reg;
    logic [WAY_W-1:0]  vic_next;
    scan_res_t         res_reg;
    scan_res_t         res_next;

    logic              cur_valid;
    logic [RANK_W-1:0] cur_rank;
    logic              hit_now;
    logic              last_now;

    // one tag compare per cycle on the selected way
    always_comb
    begin
        cur_valid = row_valid[j_reg];
        cur_rank  = row_rank[j_reg];
        hit_now   = cur_valid && (row_tag[j_reg] == tag);
        last_now  = hit_now || (j_reg == last_way);

        // first empty way
        free_next     = free_reg;
        free_way_next = free_way_reg;
        if (!free_reg && !cur_valid)
        begin
            free_next     = 1'b1;
            free_way_next = j_reg;
        end

        // oldest way, lowest number on ties
        best_next = best_reg;
        vic_next  = vic_reg;
        if (j_reg == '0)
        begin
            best_next = cur_rank;
            vic_next  = '0;
        end
        else if (cur_rank > best_reg)
        begin
            best_next = cur_rank;
            vic_next  = j_reg;
        end

        // verdict if this is the final step
        if (hit_now)
        begin
            res_next.kind = OUT_HIT;
            res_next.way  = WAY_SEL_W'(j_reg);
        end
        else if (free_next)
        begin
            res_next.kind = OUT_FILL;
            res_next.way  = WAY_SEL_W'(free_way_next);
        end
        else
        begin
            res_next.kind = OUT_EVICT;
            res_next.way  = WAY_SEL_W'(vic_next);
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last_now)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // way counter and running picks
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            j_reg    <= '0;
            free_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            j_reg        <= j_reg + 1'b1;
            free_reg     <= free_next;
            free_way_reg <= free_way_next;
            best_reg     <= best_next;
            vic_reg      <= vic_next;
            if (last_now)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

@@ rtl/core/set_assoc_lru_cache_tracker.sv @@
// channel   | handshake          | payload
// ----------+--------------------+--------------------------------------------------
// request   | in_valid/in_ready  | access_address, func
// result    | out_valid/out_ready| outcome, hit_total, miss_total, evict_total,
//           |                    | last_of_run
// config    | cfg_write          | cfg_index, cfg_data
//
// one access runs through the split, read, scan, write and done states from request to result;
// in scan the single tag comparator steps through k ways of the set (1 .. ways_in_use,
// fewer on an early hit); a modify repeats read through done for its second access
// after reset a clearing pass writes every set row once, 2**MAX_SET_INDEX_BITS rows
// (1024 by default) with in_ready low; config writes are taken meanwhile
// a result waiting on out_ready holds the next access at its final step
module set_assoc_lru_cache_tracker
    import slat_pkg::*;
#(
    parameter int MAX_SET_INDEX_BITS = MAX_SET_INDEX_BITS_DEF,
    parameter int MAX_WAYS           = MAX_WAYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_W-1:0]     access_address,
    input  logic [FUNC_W-1:0]     func,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUTCOME_W-1:0]  outcome,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [CNT_W-1:0]      evict_total,
    output logic                  last_of_run,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W   = MAX_SET_INDEX_BITS;
    localparam int WAY_W   = idx_w(MAX_WAYS);
    localparam int RANK_W  = idx_w(MAX_WAYS);
    localparam int RANK1_W = RANK_W + 1;

    state_t                          state_reg;
    state_t                          state_next;

    logic [SIB_W-1:0]                sib_reg;
    logic [BOB_W-1:0]                bob_reg;
    logic [WIU_W-1:0]                wiu_reg;

    logic [SET_W-1:0]                clr_cnt_reg;
    logic [ADDR_W-1:0]               addr_reg;
    logic                            twice_reg;
    logic [TAG_W-1:0]                tag_reg;
    logic [TAG_W-1:0]                tag_next;
    logic [SET_W-1:0]                set_reg;
    logic [SET_W-1:0]                set_next;

    logic [CNT_W-1:0]                hit_cnt_reg;
    logic [CNT_W-1:0]                miss_cnt_reg;
    logic [CNT_W-1:0]                evict_cnt_reg;

    logic                            out_valid_reg;
    outcome_t                        outcome_reg;
    logic [CNT_W-1:0]                hit_out_reg;
    logic [CNT_W-1:0]                miss_out_reg;
    logic [CNT_W-1:0]                evict_out_reg;
    logic                            last_reg;

    // clamped configuration
    logic [SIB_W-1:0]                sb;
    logic [BOB_W-1:0]                bb;
    logic [WAY_W-1:0]                last_way;
    logic [SHAMT_W-1:0]              shamt;
    logic [ADDR_W-1:0]               off_shift;
    logic [SET_W-1:0]                set_mask;

    // sequencer controls
    logic                            accept;
    logic                            out_free;
    logic                            split_en;
    logic                            scan_start;
    logic                            rd_en;
    logic                            meta_we;
    logic                            tag_we;
    logic                            clearing;
    logic                            cnt_upd;
    logic                            out_load;

    // memory and scan signals
    logic [SET_W-1:0]                wr_addr;
    logic [MAX_WAYS-1:0]             wr_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] wr_rank;
    logic [MAX_WAYS-1:0]             rd_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag;
    logic                            scan_done;
    scan_res_t                       scan_res;

    // row update
    outcome_t                        kind;
    logic [WAY_W-1:0]                way;
    logic [RANK1_W-1:0]              old_rank;
    logic [MAX_WAYS-1:0]             new_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg <= SIB_W'(1);
            bob_reg <= BOB_W'(1);
            wiu_reg <= WIU_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SET_INDEX_BITS:    sib_reg <= cfg_data[SIB_W-1:0];
                CFG_BLOCK_OFFSET_BITS: bob_reg <= cfg_data[BOB_W-1:0];
                CFG_WAYS_IN_USE:       wiu_reg <= cfg_data[WIU_W-1:0];
                default:               ;
            endcase
        end
    end

    // saturate configuration into legal ranges
    always_comb
    begin
        if (sib_reg == '0)
        begin
            sb = SIB_W'(1);
        end
        else if (int'(sib_reg) > MAX_SET_INDEX_BITS)
        begin
            sb = SIB_W'(MAX_SET_INDEX_BITS);
        end
        else
        begin
            sb = sib_reg;
        end

        if (bob_reg == '0)
        begin
            bb = BOB_W'(1);
        end
        else if (int'(bob_reg) > BOB_MAX)
        begin
            bb = BOB_W'(BOB_MAX);
        end
        else
        begin
            bb = bob_reg;
        end

        if (wiu_reg == '0)
        begin
            last_way = '0;
        end
        else if (int'(wiu_reg) > MAX_WAYS)
        begin
            last_way = WAY_W'(MAX_WAYS - 1);
        end
        else
        begin
            last_way = WAY_W'(wiu_reg - 1'b1);
        end
    end

    // address split into tag and set
    always_comb
    begin
        shamt     = SHAMT_W'(sb) + SHAMT_W'(bb);
        tag_next  = TAG_W'(addr_reg >> shamt);
        off_shift = addr_reg >> bb;
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(sb));
        end
        set_next = off_shift[SET_W-1:0] & set_mask;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: state_next = ST_READ;
            ST_READ:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = twice_reg ? ST_READ : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        in_ready   = (state_reg == ST_IDLE);
        accept     = in_ready && in_valid;
        split_en   = (state_reg == ST_SPLIT);
        scan_start = (state_reg == ST_READ);
        rd_en      = (state_reg == ST_READ);
        clearing   = (state_reg == ST_CLEAR);
        cnt_upd    = (state_reg == ST_WRITE);
        meta_we    = clearing || cnt_upd;
        tag_we     = cnt_upd;
        out_load   = (state_reg == ST_DONE) && out_free;
        wr_addr    = clearing ? clr_cnt_reg : set_reg;
        wr_valid   = clearing ? '0 : new_valid;
        wr_rank    = clearing ? '0 : new_rank;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // request capture and address split
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            twice_reg <= 1'b0;
        end
        else if (accept)
        begin
            twice_reg <= (func == FUNC_MODIFY);
        end
        else if (out_load)
        begin
            twice_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= access_address;
        end
        if (split_en)
        begin
            tag_reg <= tag_next;
            set_reg <= set_next;
        end
    end

    slat_row_mem #(
        .SET_W (SET_W),
        .WAYS  (MAX_WAYS)
    ) u_row_mem (
        .clk      (clk),
        .meta_we  (meta_we),
        .tag_we   (tag_we),
        .wr_addr  (wr_addr),
        .wr_valid (wr_valid),
        .wr_rank  (wr_rank),
        .wr_tag   (new_tag),
        .rd_en    (rd_en),
        .rd_addr  (set_reg),
        .rd_valid (rd_valid),
        .rd_rank  (rd_rank),
        .rd_tag   (rd_tag)
    );

    slat_way_scan #(
        .WAYS (MAX_WAYS)
    ) u_way_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .last_way  (last_way),
        .tag       (tag_reg),
        .row_valid (rd_valid),
        .row_rank  (rd_rank),
        .row_tag   (rd_tag),
        .done      (scan_done),
        .res       (scan_res)
    );

    // lru update of the set row: chosen way becomes newest, newer ways age
    always_comb
    begin
        kind      = scan_res.kind;
        way       = scan_res.way[WAY_W-1:0];
        old_rank  = (kind == OUT_FILL) ? RANK1_W'(MAX_WAYS) : {1'b0, rd_rank[way]};
        new_valid = rd_valid;
        new_rank  = rd_rank;
        new_tag   = rd_tag;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_W'(w) <= last_way)
            begin
                if (WAY_W'(w) == way)
                begin
                    new_rank[w] = '0;
                end
                else if (rd_valid[w] && ({1'b0, rd_rank[w]} < old_rank) &&
                         (int'(rd_rank[w]) < MAX_WAYS - 1))
                begin
                    new_rank[w] = rd_rank[w] + 1'b1;
                end
            end
        end
        if (kind == OUT_FILL)
        begin
            new_valid[way] = 1'b1;
        end
        if (kind != OUT_HIT)
        begin
            new_tag[way] = tag_reg;
        end
    end

    // saturating totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else if (cnt_upd)
        begin
            if (kind == OUT_HIT)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 1'b1;
                end
            end
            else if (miss_cnt_reg != '1)
            begin
                miss_cnt_reg <= miss_cnt_reg + 1'b1;
            end
            if ((kind == OUT_EVICT) && (evict_cnt_reg != '1))
            begin
                evict_cnt_reg <= evict_cnt_reg + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            outcome_reg   <= kind;
            hit_out_reg   <= hit_cnt_reg;
            miss_out_reg  <= miss_cnt_reg;
            evict_out_reg <= evict_cnt_reg;
            last_reg      <= !twice_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign hit_total   = hit_out_reg;
    assign miss_total  = miss_out_reg;
    assign evict_total = evict_out_reg;
    assign last_of_run = last_reg;

endmodule

@@ tb/tb_set_assoc_lru_cache_tracker.sv @@
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tracker;
    import slat_pkg::*;

    localparam int NUM_SETS          = 1 << MAX_SET_INDEX_BITS_DEF;
    localparam int NUM_LINES         = NUM_SETS * MAX_WAYS_DEF;
    localparam int OLDEST_RANK       = MAX_WAYS_DEF - 1;
    localparam int ITEMS_PER_PHASE   = 185;
    localparam int CYCLE_LIMIT       = 600000;
    localparam int SETTLE_CYCLES     = 40;
    localparam int LONG_HOLD_AT      = 120;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS       = 100;

    // access kinds not named in the package
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // one result as it should leave the block
    typedef struct packed {
        outcome_t           outcome;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   evicts;
        logic               last;
    } access_result_t;

    // directed request, with the outcome typed in where it is obvious
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [FUNC_W-1:0]  kind;
        logic               pinned;
        outcome_t           first;
        outcome_t           second;
    } probe_row_t;

    // raw register values for one random phase
    typedef struct packed {
        logic [CFG_DATA_W-1:0] sib;
        logic [CFG_DATA_W-1:0] bob;
        logic [CFG_DATA_W-1:0] wiu;
    } run_config_t;

    typedef enum {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE} drain_mode_t;

    // reset geometry: 2 sets, 2-byte blocks, one way
    localparam int NUM_PROBES = 12;
    localparam probe_row_t PROBE_ROWS [NUM_PROBES] = '{
        '{64'h0000_0000_0000_0000, FUNC_LOAD,   1'b1, OUT_FILL,  OUT_HIT},
        '{64'h0000_0000_0000_0001, FUNC_STORE,  1'b1, OUT_HIT,   OUT_HIT},
        '{64'h0000_0000_0000_0002, FUNC_LOAD,   1'b1, OUT_FILL,  OUT_HIT},
        '{64'h0000_0000_0000_0004, FUNC_LOAD,   1'b1, OUT_EVICT, OUT_HIT},
        '{64'h0000_0000_0000_0000, FUNC_MODIFY, 1'b1, OUT_EVICT, OUT_HIT},
        '{64'hFFFF_FFFF_FFFF_FFFF, FUNC_SPARE,  1'b1, OUT_EVICT, OUT_HIT},
        '{64'hFFFF_FFFF_FFFF_FFFE, FUNC_STORE,  1'b1, OUT_HIT,   OUT_HIT},
        '{64'h8000_0000_0000_0000, FUNC_MODIFY, 1'b1, OUT_EVICT, OUT_HIT},
        '{64'h5555_5555_5555_5555, FUNC_LOAD,   1'b0, OUT_HIT,   OUT_HIT},
        '{64'hAAAA_AAAA_AAAA_AAAA, FUNC_STORE,  1'b0, OUT_HIT,   OUT_HIT},
        '{64'h0000_0000_0000_0003, FUNC_MODIFY, 1'b0, OUT_HIT,   OUT_HIT},
        '{64'h7FFF_FFFF_FFFF_FFFF, FUNC_LOAD,   1'b0, OUT_HIT,   OUT_HIT}
    };

    // geometries for the random phases, out of range values included
    localparam int NUM_RUN_CONFIGS = 8;
    localparam run_config_t RUN_CONFIGS [NUM_RUN_CONFIGS] = '{
        '{6'd3,  6'd6,  6'd4},
        '{6'd0,  6'd0,  6'd0},
        '{6'd15, 6'd63, 6'd15},
        '{6'd10, 6'd32, 6'd8},
        '{6'd2,  6'd4,  6'd2},
        '{6'd1,  6'd1,  6'd1},
        '{6'd6,  6'd20, 6'd8},
        '{6'd10, 6'd2,  6'd3}
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [ADDR_W-1:0]      access_address = '0;
    logic [FUNC_W-1:0]      func = FUNC_LOAD;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [OUTCOME_W-1:0]   outcome;
    logic [CNT_W-1:0]       hit_total;
    logic [CNT_W-1:0]       miss_total;
    logic [CNT_W-1:0]       evict_total;
    logic                   last_of_run;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_SET_INDEX_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow copy of the cache contents and registers
    logic                   shadow_valid [NUM_LINES];
    logic [TAG_W-1:0]       shadow_tag [NUM_LINES];
    logic [2:0]             shadow_rank [NUM_LINES];
    logic [CNT_W-1:0]       shadow_hits;
    logic [CNT_W-1:0]       shadow_misses;
    logic [CNT_W-1:0]       shadow_evicts;
    logic [SIB_W-1:0]       sib_reg;
    logic [BOB_W-1:0]       bob_reg;
    logic [WIU_W-1:0]       wiu_reg;

    access_result_t         awaited_results [$];

    int fail_count = 0;
    int sent_count = 0;
    int results_seen = 0;
    int cfg_count = 0;
    int seen_hits = 0;
    int seen_fills = 0;
    int seen_evicts = 0;
    int burst_left = 0;
    int cycle_count = 0;

    set_assoc_lru_cache_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .access_address (access_address),
        .func           (func),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outcome        (outcome),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .evict_total    (evict_total),
        .last_of_run    (last_of_run),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] bump_total(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // register write as the block sees it
    function automatic void shadow_config(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SET_INDEX_BITS:    sib_reg = data[SIB_W-1:0];
            CFG_BLOCK_OFFSET_BITS: bob_reg = data[BOB_W-1:0];
            CFG_WAYS_IN_USE:       wiu_reg = data[WIU_W-1:0];
            default:               ;
        endcase
    endfunction

    // way w becomes newest, newer valid ways age by one
    function automatic void promote_way(input int base, input int nw, input int w,
                                        input int old_rank);
        for (int j = 0; j < nw; j++)
        begin
            if (j != w && shadow_valid[base + j] && int'(shadow_rank[base + j]) < old_rank
                && int'(shadow_rank[base + j]) < OLDEST_RANK)
                shadow_rank[base + j] = shadow_rank[base + j] + 3'd1;
        end
        shadow_rank[base + w] = 3'd0;
    endfunction

    // one lookup with fill or lru eviction
    function automatic outcome_t cache_lookup(input logic [ADDR_W-1:0] addr);
        int sb;
        int bb;
        int nw;
        int base;
        int victim;
        int best;
        logic [TAG_W-1:0] tag;
        logic [ADDR_W-1:0] set_sel;
        sb = clamp_int(int'(sib_reg), 1, MAX_SET_INDEX_BITS_DEF);
        bb = clamp_int(int'(bob_reg), 1, BOB_MAX);
        nw = clamp_int(int'(wiu_reg), 1, MAX_WAYS_DEF);
        tag = TAG_W'(addr >> (sb + bb));
        set_sel = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        base = int'(set_sel) * MAX_WAYS_DEF;

        for (int j = 0; j < nw; j++)
        begin
            if (shadow_valid[base + j] && shadow_tag[base + j] == tag)
            begin
                shadow_hits = bump_total(shadow_hits);
                promote_way(base, nw, j, int'(shadow_rank[base + j]));
                return OUT_HIT;
            end
        end
        shadow_misses = bump_total(shadow_misses);

        for (int j = 0; j < nw; j++)
        begin
            if (!shadow_valid[base + j])
            begin
                shadow_valid[base + j] = 1'b1;
                shadow_tag[base + j] = tag;
                promote_way(base, nw, j, MAX_WAYS_DEF);
                return OUT_FILL;
            end
        end

        // every active way taken: oldest goes, lowest way on a tie
        shadow_evicts = bump_total(shadow_evicts);
        victim = 0;
        best = int'(shadow_rank[base]);
        for (int j = 1; j < nw; j++)
        begin
            if (int'(shadow_rank[base + j]) > best)
            begin
                best = int'(shadow_rank[base + j]);
                victim = j;
            end
        end
        shadow_tag[base + victim] = tag;
        promote_way(base, nw, victim, best);
        return OUT_EVICT;
    endfunction

    // queue the results one request must produce
    function automatic void queue_outcomes(input logic [ADDR_W-1:0] addr,
                                           input logic [FUNC_W-1:0] kind,
                                           input logic pinned,
                                           input outcome_t first,
                                           input outcome_t second);
        access_result_t res;
        int n;
        n = (kind == FUNC_MODIFY) ? 2 : 1;
        for (int r = 0; r < n; r++)
        begin
            res.outcome = cache_lookup(addr);
            if (pinned)
                res.outcome = (r == 0) ? first : second;
            res.hits = shadow_hits;
            res.misses = shadow_misses;
            res.evicts = shadow_evicts;
            res.last = (r == n - 1);
            awaited_results.push_back(res);
        end
    endfunction

    // random address, mostly a few tags over a few sets so lines get reused
    function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] tag_base);
        int sb;
        int bb;
        int nw;
        int nsets;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] set_sel;
        logic [ADDR_W-1:0] off;
        sb = clamp_int(int'(sib_reg), 1, MAX_SET_INDEX_BITS_DEF);
        bb = clamp_int(int'(bob_reg), 1, BOB_MAX);
        nw = clamp_int(int'(wiu_reg), 1, MAX_WAYS_DEF);
        nsets = 1 << sb;
        if ($urandom_range(0, 99) < 15)
            return {$urandom, $urandom};
        tag = tag_base + 64'($urandom_range(0, nw + 1));
        if ($urandom_range(0, 9) == 0)
            set_sel = 64'($urandom_range(0, nsets - 1));
        else
            set_sel = 64'($urandom_range(0, (nsets < 4) ? nsets - 1 : 3));
        off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
        return (tag << (sb + bb)) | (set_sel << bb) | off;
    endfunction

    // one register write, strobe left high for the caller to drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        shadow_config(idx, data);
        cfg_count++;
    endtask

    task automatic apply_geometry(input run_config_t rc);
        write_reg(CFG_SET_INDEX_BITS, rc.sib);
        write_reg(CFG_BLOCK_OFFSET_BITS, rc.bob);
        write_reg(CFG_WAYS_IN_USE, rc.wiu);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // offer one request in bursts with random gaps, return once accepted
    task automatic send_request(input logic [ADDR_W-1:0] addr,
                                input logic [FUNC_W-1:0] kind,
                                input logic pinned,
                                input outcome_t first,
                                input outcome_t second);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        access_address <= addr;
        func <= kind;
        do
            @(posedge clk);
        while (!in_ready);
        queue_outcomes(addr, kind, pinned, first, second);
        sent_count++;
    endtask

    // stop offering, let every result out, then let the block settle
    task automatic drain_phase();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // result checker and output stall pattern
    initial
    begin : result_checker
        access_result_t want;
        drain_mode_t mode;
        int seg_left;
        int hold_left;
        bit hold_done;
        mode = DRAIN_FULL;
        seg_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (outcome == OUT_HIT)
                    seen_hits++;
                else if (outcome == OUT_FILL)
                    seen_fills++;
                else
                    seen_evicts++;
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("result with no request pending: outcome %0d", outcome);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (outcome !== want.outcome)
                        note_mismatch("outcome", 64'(want.outcome), 64'(outcome));
                    if (hit_total !== want.hits)
                        note_mismatch("hit_total", 64'(want.hits), 64'(hit_total));
                    if (miss_total !== want.misses)
                        note_mismatch("miss_total", 64'(want.misses), 64'(miss_total));
                    if (evict_total !== want.evicts)
                        note_mismatch("evict_total", 64'(want.evicts), 64'(evict_total));
                    if (last_of_run !== want.last)
                        note_mismatch("last_of_run", 64'(want.last), 64'(last_of_run));
                end
                // one long hold so the block backs up into its input
                if (results_seen == LONG_HOLD_AT && !hold_done)
                begin
                    hold_left = LONG_HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = drain_mode_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (mode)
                    DRAIN_FULL: out_ready <= 1'b1;
                    DRAIN_HALF: out_ready <= 1'($urandom_range(0, 1));
                    default:    out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [ADDR_W-1:0] tag_base;
        for (int i = 0; i < NUM_LINES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i] = '0;
            shadow_rank[i] = 3'd0;
        end
        shadow_hits = '0;
        shadow_misses = '0;
        shadow_evicts = '0;
        sib_reg = SIB_W'(1);
        bob_reg = BOB_W'(1);
        wiu_reg = WIU_W'(1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // write to a missing register during the clearing pass, must change nothing
        write_reg(CFG_UNUSED, '1);
        @(posedge clk);
        cfg_write <= 1'b0;

        // directed requests on the reset geometry
        for (int i = 0; i < NUM_PROBES; i++)
            send_request(PROBE_ROWS[i].addr, PROBE_ROWS[i].kind, PROBE_ROWS[i].pinned,
                         PROBE_ROWS[i].first, PROBE_ROWS[i].second);
        drain_phase();

        // random phases, cache contents carried across geometry changes
        for (int p = 0; p < NUM_RUN_CONFIGS; p++)
        begin
            apply_geometry(RUN_CONFIGS[p]);
            tag_base = {$urandom, $urandom};
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(pick_address(tag_base), FUNC_W'($urandom_range(0, 3)), 1'b0,
                             OUT_HIT, OUT_HIT);
            drain_phase();
        end

        $display("sent %0d requests over %0d geometries with %0d register writes",
                 sent_count, NUM_RUN_CONFIGS + 1, cfg_count);
        $display("checked %0d results: %0d hits, %0d fills, %0d evictions",
                 results_seen, seen_hits, seen_fills, seen_evicts);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
